/* hw/rtl/fpa_pkg.sv */
package fpa_pkg;

    // Default sizes handed to the top level
    localparam int NUM_PARTITIONS_DEF = 16;
    localparam int NUM_SLOTS_DEF      = 16;

    // Configuration register map
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_PARTITION_SIZE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS   = 1'd1;

    // Reset values of the configuration registers
    localparam logic [15:0] PARTITION_SIZE_RST = 16'd1024;
    localparam logic [31:0] BASE_ADDRESS_RST   = 32'd10240;

    localparam int JOB_W = 8;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_NOFIT = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_NOJOB = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADDR
    } state_t;

    localparam logic KIND_ALLOCATE = 1'b0;
    localparam logic KIND_RECLAIM  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [JOB_W-1:0] job_id;
        logic [15:0]      request_length;
    } fpa_in_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] start_address;
        logic [3:0]  partition_index;
    } fpa_out_t;

    // Update strobes broadcast to every cell of both rows
    typedef struct packed {
        logic alloc_en;
        logic free_en;
    } fpa_cmd_t;

endpackage

/* hw/rtl/fixed_partition_allocator.sv */
// Channel | Signals                     | Beat
// --------+-----------------------------+--------------------------------------
// in      | in_valid in_ready in_data   | kind, job_id, request_length
// out     | out_valid out_ready out_data| status, start_address, partition_index
// cfg     | cfg_we cfg_index cfg_data   | 0 partition_size, 1 base_address
//
// A request goes through these steps from accept to result: latch, one pass down
// the partition and slot cell rows (priority chains plus state update), then
// the start address multiply-add into the output register.
// A new request is taken once the previous one has left the address stage;
// a waiting result does not block it. Reset clears all cells at once.
// A stalled output holds the address stage until out_ready.
module fixed_partition_allocator #(
    parameter int NUM_PARTITIONS = fpa_pkg::NUM_PARTITIONS_DEF,
    parameter int NUM_SLOTS      = fpa_pkg::NUM_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  fpa_pkg::fpa_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output fpa_pkg::fpa_out_t                out_data
);

    localparam int IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

    // configuration
    logic [15:0] size_reg;
    logic [31:0] base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fpa_pkg::PARTITION_SIZE_RST;
            base_reg <= fpa_pkg::BASE_ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fpa_pkg::CFG_PARTITION_SIZE: size_reg <= cfg_data[15:0];
                fpa_pkg::CFG_BASE_ADDRESS:   base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    fpa_pkg::state_t  state_reg;
    fpa_pkg::state_t  state_next;
    fpa_pkg::fpa_in_t req_reg;
    fpa_pkg::status_t status_reg;
    fpa_pkg::status_t status_next;
    logic [IW-1:0]    idx_reg;
    logic [IW-1:0]    idx_next;
    fpa_pkg::fpa_out_t out_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             load_out;
    logic             do_alloc;
    logic             do_free;
    fpa_pkg::fpa_cmd_t cmd;

    // cell chains
    logic          p_found [NUM_PARTITIONS+1];
    logic [IW-1:0] p_idx   [NUM_PARTITIONS+1];
    logic          s_empty [NUM_SLOTS+1];
    logic          s_match [NUM_SLOTS+1];
    logic [IW-1:0] s_part  [NUM_SLOTS+1];
    logic          fit;

    assign fit        = size_reg >= req_reg.request_length;
    assign p_found[0] = 1'b0;
    assign p_idx[0]   = '0;
    assign s_empty[0] = 1'b0;
    assign s_match[0] = 1'b0;
    assign s_part[0]  = '0;

    genvar gp;
    generate
        for (gp = 0; gp < NUM_PARTITIONS; gp++)
        begin : g_part
            fpa_part_cell #(
                .IW       (IW),
                .CELL_IDX (gp)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .fit       (fit),
                .free_idx  (s_part[NUM_SLOTS]),
                .found_in  (p_found[gp]),
                .idx_in    (p_idx[gp]),
                .found_out (p_found[gp+1]),
                .idx_out   (p_idx[gp+1])
            );
        end
    endgenerate

    genvar gs;
    generate
        for (gs = 0; gs < NUM_SLOTS; gs++)
        begin : g_slot
            fpa_slot_cell #(
                .IW (IW)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .job       (req_reg.job_id),
                .alloc_idx (p_idx[NUM_PARTITIONS]),
                .empty_in  (s_empty[gs]),
                .empty_out (s_empty[gs+1]),
                .match_in  (s_match[gs]),
                .part_in   (s_part[gs]),
                .match_out (s_match[gs+1]),
                .part_out  (s_part[gs+1])
            );
        end
    endgenerate

    // decide the outcome from the chain ends
    always_comb
    begin
        status_next = fpa_pkg::STATUS_OK;
        idx_next    = '0;
        do_alloc    = 1'b0;
        do_free     = 1'b0;
        if (req_reg.kind == fpa_pkg::KIND_ALLOCATE)
        begin
            if (req_reg.job_id == '0)
            begin
                status_next = fpa_pkg::STATUS_FULL;
            end
            else if (!p_found[NUM_PARTITIONS])
            begin
                status_next = fpa_pkg::STATUS_NOFIT;
            end
            else if (!s_empty[NUM_SLOTS])
            begin
                status_next = fpa_pkg::STATUS_FULL;
            end
            else
            begin
                idx_next = p_idx[NUM_PARTITIONS];
                do_alloc = 1'b1;
            end
        end
        else
        begin
            if (s_match[NUM_SLOTS])
            begin
                idx_next = s_part[NUM_SLOTS];
                do_free  = 1'b1;
            end
            else
            begin
                status_next = fpa_pkg::STATUS_NOJOB;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fpa_pkg::ST_SEARCH;
                end
            end
            fpa_pkg::ST_SEARCH:
            begin
                state_next = fpa_pkg::ST_ADDR;
            end
            fpa_pkg::ST_ADDR:
            begin
                if (out_free)
                begin
                    state_next = fpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpa_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.alloc_en = 1'b0;
        cmd.free_en  = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            fpa_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            fpa_pkg::ST_SEARCH:
            begin
                cmd.alloc_en = do_alloc;
                cmd.free_en  = do_free;
            end
            fpa_pkg::ST_ADDR:
            begin
                load_out = out_free;
            end
            default: ;
        endcase
    end

    // start address: base + index * size, wraps at 32 bits
    logic [IW+15:0]    prod;
    logic [IW+3:0]     idx_ext;
    fpa_pkg::fpa_out_t out_next;

    assign prod    = {{16{1'b0}}, idx_reg} * {{IW{1'b0}}, size_reg};
    assign idx_ext = {4'b0000, idx_reg};

    always_comb
    begin
        out_next.status          = status_reg;
        out_next.start_address   = '0;
        out_next.partition_index = '0;
        if (status_reg == fpa_pkg::STATUS_OK)
        begin
            out_next.start_address   = base_reg + 32'(prod);
            out_next.partition_index = idx_ext[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fpa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_data;
        end
        if (state_reg == fpa_pkg::ST_SEARCH)
        begin
            status_reg <= status_next;
            idx_reg    <= idx_next;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* hw/rtl/fpa_part_cell.sv */
module fpa_part_cell #(
    parameter int IW       = 4,
    parameter int CELL_IDX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fpa_pkg::fpa_cmd_t cmd,
    input  logic              fit,
    input  logic [IW-1:0]     free_idx,
    input  logic              found_in,
    input  logic [IW-1:0]     idx_in,
    output logic              found_out,
    output logic [IW-1:0]     idx_out
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic busy_reg;
    logic busy_next;
    logic sel;

    // first free partition that fits wins; lower cells block the rest
    assign sel       = !found_in && !busy_reg && fit;
    assign found_out = found_in || (!busy_reg && fit);
    assign idx_out   = sel ? MY_IDX : idx_in;

    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.alloc_en && sel)
        begin
            busy_next = 1'b1;
        end
        else if (cmd.free_en && free_idx == MY_IDX)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

endmodule

/* hw/rtl/fpa_slot_cell.sv */
module fpa_slot_cell #(
    parameter int IW = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fpa_pkg::fpa_cmd_t        cmd,
    input  logic [fpa_pkg::JOB_W-1:0] job,
    input  logic [IW-1:0]            alloc_idx,
    input  logic                     empty_in,
    output logic                     empty_out,
    input  logic                     match_in,
    input  logic [IW-1:0]            part_in,
    output logic                     match_out,
    output logic [IW-1:0]            part_out
);

    logic [fpa_pkg::JOB_W-1:0] job_reg;
    logic [fpa_pkg::JOB_W-1:0] job_next;
    logic [IW-1:0]             part_reg;
    logic [IW-1:0]             part_next;
    logic                      is_empty;
    logic                      hit;
    logic                      empty_sel;
    logic                      match_sel;

    // empty chain: first free slot; match chain: first slot holding the job
    assign is_empty  = job_reg == '0;
    assign hit       = (job != '0) && (job_reg == job);
    assign empty_sel = !empty_in && is_empty;
    assign match_sel = !match_in && hit;
    assign empty_out = empty_in || is_empty;
    assign match_out = match_in || hit;
    assign part_out  = match_sel ? part_reg : part_in;

    always_comb
    begin
        job_next  = job_reg;
        part_next = part_reg;
        if (cmd.alloc_en && empty_sel)
        begin
            job_next  = job;
            part_next = alloc_idx;
        end
        else if (cmd.free_en && match_sel)
        begin
            job_next  = '0;
            part_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_reg  <= '0;
            part_reg <= '0;
        end
        else
        begin
            job_reg  <= job_next;
            part_reg <= part_next;
        end
    end

endmodule
